/* rtl/plq_pkg.sv */
// Phase level quantizer: shared widths, opcodes and controller/datapath types.
// No dependencies; imported by every module of the block.
package plq_pkg;

  // Threshold table and field widths
  localparam int LEVEL_COUNT = 17;
  localparam int CNT_W       = $clog2(LEVEL_COUNT + 1);
  localparam int PHASE_W     = 16;
  localparam int SLOT_W      = 5;
  localparam int LEVEL_W     = 5;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 8;

  // Item opcodes (carried on in_tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUANT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic tbl_we;    // write one threshold entry
    logic px_load;   // capture a pixel and its frame-end flag
    logic match_en;  // register the first matching interval
    logic out_load;  // load the result register
  } plq_cmd_t;

endpackage

/* rtl/phase_level_quantizer_unit.sv */
// Phase level quantizer top level: stream ports, controller and datapath.
// Pixel path: after acceptance the pixel passes the interval match state, then
//   the pick state, which sets out_tvalid and waits while the previous result is still held.
// Pixels: a new pixel is accepted only after the previous one has left the pick state;
//   table writes give no result and leave the controller idle.
// Reset: synchronous, active low; clears control state and all 17 table
//   entries at once, so no clearing pass is needed.
module phase_level_quantizer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [plq_pkg::IN_DATA_W-1:0]    in_tdata,  // table_slot[4:0], phase_value[20:5]
  input  logic                             in_tuser,  // opcode
  input  logic                             in_tlast,  // end_of_frame
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [plq_pkg::OUT_DATA_W-1:0]   out_tdata, // level[4:0]
  output logic                             out_tlast  // frame_end
);
  import plq_pkg::*;

  plq_cmd_t            cmd;
  logic [LEVEL_W-1:0]  level;

  plq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  plq_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .table_slot   (in_tdata[SLOT_W-1:0]),
    .phase_value  (in_tdata[SLOT_W +: PHASE_W]),
    .end_of_frame (in_tlast),
    .level        (level),
    .frame_end    (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'(level);

endmodule

/* rtl/plq_ctrl.sv */
// Phase level quantizer controller: sequencer and output valid register.
// Depends on plq_pkg.
module plq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_opcode,
  output logic             in_tready,
  input  logic             out_tready,
  output logic             out_tvalid,
  output plq_pkg::plq_cmd_t cmd
);
  import plq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_PICK  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Sequencer
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_opcode == OP_WRITE) begin
            cmd.tbl_we = 1'b1;
          end else begin
            cmd.px_load = 1'b1;
            state_nxt   = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        cmd.match_en = 1'b1;
        state_nxt    = S_PICK;
      end
      S_PICK: begin
        // wait for the result register to drain
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_match_to_pick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MATCH |=> state_r == S_PICK)
    else $error("match step not followed by pick step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before taken");

  a_pixel_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_opcode == OP_QUANT) |=> state_r == S_MATCH)
    else $error("accepted pixel did not start the sequence");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_opcode == OP_WRITE) |=> state_r == S_IDLE)
    else $error("table write left idle");
`endif

endmodule

/* rtl/plq_datapath.sv */
// Phase level quantizer datapath: threshold table, interval match,
// distance compare and result register. Depends on plq_pkg.
module plq_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  plq_pkg::plq_cmd_t               cmd,
  input  logic [plq_pkg::SLOT_W-1:0]      table_slot,
  input  logic signed [plq_pkg::PHASE_W-1:0] phase_value,
  input  logic                            end_of_frame,
  output logic [plq_pkg::LEVEL_W-1:0]     level,
  output logic                            frame_end
);
  import plq_pkg::*;

  localparam logic [CNT_W-1:0] LEVEL_MOD = CNT_W'(LEVEL_COUNT - 1);

  logic signed [PHASE_W-1:0] tbl_r  [LEVEL_COUNT];
  logic signed [PHASE_W-1:0] hi_tab [LEVEL_COUNT];
  logic signed [PHASE_W-1:0] x_r;
  logic                      eof_r;
  logic [LEVEL_COUNT-1:0]    match;
  logic [LEVEL_COUNT-1:0]    first_nxt, first_r;
  logic signed [PHASE_W-1:0] lo_sel, hi_sel;
  logic [CNT_W-1:0]          k_sel, up, level_nxt;
  logic signed [PHASE_W:0]   dlo, dhi;
  logic [LEVEL_W-1:0]        out_level_r;
  logic                      out_frame_end_r;

  // Threshold table, cleared by reset; out-of-range slots are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        tbl_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        if (cmd.tbl_we && int'(table_slot) == i) begin
          tbl_r[i] <= phase_value;
        end
      end
    end
  end

  // Upper bound of each interval; the last one is a fixed zero
  always_comb begin
    for (int k = 0; k < LEVEL_COUNT - 1; k++) begin
      hi_tab[k] = tbl_r[k + 1];
    end
    hi_tab[LEVEL_COUNT-1] = '0;
  end

  // Strict interval test for every k, then isolate the lowest hit
  always_comb begin
    for (int k = 0; k < LEVEL_COUNT; k++) begin
      match[k] = (x_r > tbl_r[k]) && (x_r < hi_tab[k]);
    end
    first_nxt = match & (~match + 1'b1);
  end

  // Bounds and index of the selected interval
  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    k_sel  = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (first_r[i]) begin
        lo_sel = lo_sel | tbl_r[i];
        hi_sel = hi_sel | hi_tab[i];
        k_sel  = k_sel | CNT_W'(i);
      end
    end
  end

  // Nearer bound wins; a tie goes to the upper level, wrapped; no hit gives level 0
  always_comb begin
    dlo = {x_r[PHASE_W-1], x_r} - {lo_sel[PHASE_W-1], lo_sel};
    dhi = {hi_sel[PHASE_W-1], hi_sel} - {x_r[PHASE_W-1], x_r};
    up  = k_sel + 1'b1;
    if (up >= LEVEL_MOD) begin
      up = up - LEVEL_MOD;
    end
    if (up >= LEVEL_MOD) begin
      up = up - LEVEL_MOD;
    end
    if (first_r == '0) begin
      level_nxt = '0;
    end else if (dlo < dhi) begin
      level_nxt = k_sel;
    end else begin
      level_nxt = up;
    end
  end

  // Pixel, match and result registers (payload only)
  always_ff @(posedge clk) begin
    if (cmd.px_load) begin
      x_r   <= phase_value;
      eof_r <= end_of_frame;
    end
    if (cmd.match_en) begin
      first_r <= first_nxt;
    end
    if (cmd.out_load) begin
      out_level_r     <= LEVEL_W'(level_nxt);
      out_frame_end_r <= eof_r;
    end
  end

  assign level     = out_level_r;
  assign frame_end = out_frame_end_r;

`ifndef ASSERT_OFF
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> $onehot0(first_r))
    else $error("more than one interval selected");
`endif

endmodule
